FILE: hdl/sactc_pkg.sv
// ----------------------------------------------------------------------------
// sactc_pkg
// Shared types, constants and helpers of the cache tag controller.
// ----------------------------------------------------------------------------
package sactc_pkg;

    localparam int LINES      = 256;
    localparam int LANES      = 8;
    localparam int ROWS       = LINES / LANES;
    localparam int LINE_W     = $clog2(LINES);
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int AGE_W      = 3;
    localparam int RAM_W      = TAG_W + AGE_W;
    localparam int MW_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_LOG2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 3'd5;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOOK,
        B_FLUSH
    } t_bstate;

    typedef struct packed {
        logic       write_policy;
        logic       replace_policy;
        logic [3:0] offset_bits;
        logic [3:0] line_count_log2;
        logic [1:0] ways_log2;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [LINE_W-1:0] base;
        logic [TAG_W-1:0]  tag;
    } t_item;

    typedef struct packed {
        logic                  hit;
        logic                  allocated;
        logic [LINE_W-1:0]     line_index;
        logic                  mem_reads;
        logic [MW_W-1:0]       mem_writes;
    } t_result;

    typedef struct packed {
        logic        load;
        logic [15:0] seed;
    } t_seed;

    function automatic logic [3:0] lines_log2_eff(input t_cfg c);
        return (c.line_count_log2 > 4'(LINE_W)) ? 4'(LINE_W) : c.line_count_log2;
    endfunction

    function automatic logic [1:0] ways_log2_eff(input t_cfg c);
        logic [3:0] l;
        l = lines_log2_eff(c);
        return ({2'b00, c.ways_log2} > l) ? l[1:0] : c.ways_log2;
    endfunction

endpackage

FILE: hdl/sactc_ram.sv
// ----------------------------------------------------------------------------
// sactc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sactc_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hdl/sactc_front.sv
// ----------------------------------------------------------------------------
// sactc_front
// Splits each address into set base and tag and queues the decoded word.
// ----------------------------------------------------------------------------
module sactc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sactc_pkg::t_cfg                i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [sactc_pkg::ADDR_W-1:0]   i_addr,
    output logic                           o_qvalid,
    output sactc_pkg::t_item               o_item,
    input  logic                           i_pop
);
    import sactc_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        push;
    t_item       dec;
    logic [ADDR_W-1:0] blk;
    logic [3:0]  set_bits;
    logic [1:0]  wl;
    logic [LINE_W-1:0] set_idx;

    always_comb begin
        wl       = ways_log2_eff(i_cfg);
        set_bits = lines_log2_eff(i_cfg) - {2'b00, wl};
        blk      = i_addr >> i_cfg.offset_bits;
        set_idx  = blk[LINE_W-1:0] & ~(8'hFF << set_bits);
        dec.cmd  = t_cmd'(i_cmd);
        dec.base = set_idx << wl;
        dec.tag  = TAG_W'(blk >> set_bits);
    end

    assign o_ready  = (r_cnt != 2'd2);
    assign push     = i_valid && o_ready;
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_item   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= r_wp ^ push;
            r_rp  <= r_rp ^ i_pop;
            r_cnt <= n_cnt;
        end
    end
endmodule

FILE: hdl/sactc_back.sv
// ----------------------------------------------------------------------------
// sactc_back
// Tag lookup, replacement, age and dirty update, flush walk, result register.
// ----------------------------------------------------------------------------
module sactc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sactc_pkg::t_cfg       i_cfg,
    input  sactc_pkg::t_seed      i_seed,
    input  logic                  i_qvalid,
    input  sactc_pkg::t_item      i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sactc_pkg::t_result    o_result
);
    import sactc_pkg::*;

    t_bstate            r_state, n_state;
    t_item              r_item;
    logic [LINES-1:0]   r_valid, n_valid;
    logic [LINES-1:0]   r_dirty, n_dirty;
    logic [15:0]        r_lfsr, n_lfsr;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [MW_W-1:0]    r_fcnt, n_fcnt;
    logic               r_ovalid, n_ovalid;
    t_result            r_res, n_res;

    logic [RAM_W-1:0]   rd [LANES];
    logic [RAM_W-1:0]   wd [LANES];
    logic [LANES-1:0]   we;
    logic [ROW_W-1:0]   raddr;

    logic [TAG_W-1:0]   rtag [LANES];
    logic [AGE_W-1:0]   rage [LANES];
    logic [LANES-1:0]   vld, drt, ins;
    logic [LINE_W-1:0]  lidx [LANES];
    logic [2:0]         wm;
    logic               found, inv_f, age_f;
    logic [LANE_W-1:0]  hl, il, al, tl;
    logic [AGE_W-1:0]   ref_age;
    logic [15:0]        lfsr_nx;
    logic               start, fill;
    logic [LINE_W-1:0]  fl;
    logic [8:0]         lim;
    logic [MW_W-1:0]    pc;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            sactc_ram #(.WIDTH(RAM_W), .DEPTH(ROWS)) u_ram (
                .i_clk   (i_clk),
                .i_we    (we[g]),
                .i_waddr (r_item.base[LINE_W-1:LANE_W]),
                .i_wdata (wd[g]),
                .i_raddr (raddr),
                .o_rdata (rd[g])
            );
        end
    endgenerate

    assign start   = (r_state == B_IDLE) && i_qvalid && (!r_ovalid || i_ready);
    assign o_pop   = start;
    assign raddr   = i_item.base[LINE_W-1:LANE_W];
    assign lfsr_nx = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'h0000);

    // set view of the row just read
    always_comb begin
        wm = 3'((4'd1 << ways_log2_eff(i_cfg)) - 4'd1);
        for (int l = 0; l < LANES; l++) begin
            rtag[l] = rd[l][RAM_W-1:AGE_W];
            rage[l] = rd[l][AGE_W-1:0];
            lidx[l] = {r_item.base[LINE_W-1:LANE_W], LANE_W'(l)};
            vld[l]  = r_valid[lidx[l]];
            drt[l]  = r_dirty[lidx[l]];
            ins[l]  = ((LANE_W'(l) ^ r_item.base[LANE_W-1:0]) & ~wm) == 3'd0;
        end
        found = 1'b0; hl = '0;
        inv_f = 1'b0; il = '0;
        age_f = 1'b0; al = '0;
        for (int l = 0; l < LANES; l++) begin
            if (!found && ins[l] && vld[l] && rtag[l] == r_item.tag) begin
                found = 1'b1; hl = LANE_W'(l);
            end
            if (!inv_f && ins[l] && !vld[l]) begin
                inv_f = 1'b1; il = LANE_W'(l);
            end
            if (!age_f && ins[l] && rage[l] == '0) begin
                age_f = 1'b1; al = LANE_W'(l);
            end
        end
        ref_age = rage[hl];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (start) n_state = B_LOOK;
            end
            B_LOOK: begin
                if (r_item.cmd == CMD_FLUSH && i_cfg.write_policy) n_state = B_FLUSH;
                else n_state = B_IDLE;
            end
            B_FLUSH: begin
                if (r_row == ROW_W'(ROWS - 1)) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_valid  = r_valid;
        n_dirty  = r_dirty;
        n_lfsr   = r_lfsr;
        n_row    = r_row;
        n_fcnt   = r_fcnt;
        n_ovalid = r_ovalid && !i_ready;
        n_res    = r_res;
        we       = '0;
        fill     = 1'b0;
        tl       = hl;
        lim      = 9'd1 << lines_log2_eff(i_cfg);
        pc       = '0;
        fl       = '0;
        for (int l = 0; l < LANES; l++) begin
            wd[l] = rd[l];
        end
        case (r_state)
            B_IDLE: begin
                n_row  = '0;
                n_fcnt = '0;
            end
            B_LOOK: begin
                if (!(r_item.cmd == CMD_FLUSH && i_cfg.write_policy)) begin
                    n_ovalid = 1'b1;
                    n_res    = '0;
                end
                if (r_item.cmd == CMD_READ || r_item.cmd == CMD_WRITE) begin
                    if (found) begin
                        n_res.hit        = 1'b1;
                        n_res.line_index = lidx[hl];
                        if (r_item.cmd == CMD_WRITE) begin
                            if (!i_cfg.write_policy) n_res.mem_writes = 9'd1;
                            else n_dirty[lidx[hl]] = 1'b1;
                        end
                    end else if (r_item.cmd == CMD_WRITE && !i_cfg.write_policy) begin
                        n_res.mem_writes = 9'd1;
                    end else begin
                        fill = 1'b1;
                        if (inv_f) begin
                            tl = il;
                        end else if (!i_cfg.replace_policy && age_f) begin
                            tl = al;
                        end else begin
                            n_lfsr = lfsr_nx;
                            tl = r_item.base[LANE_W-1:0] | (lfsr_nx[LANE_W-1:0] & wm);
                        end
                        fl = lidx[tl];
                        if (i_cfg.write_policy && vld[tl] && drt[tl]) n_res.mem_writes = 9'd1;
                        n_res.mem_reads  = 1'b1;
                        n_res.allocated  = 1'b1;
                        n_res.line_index = fl;
                        n_valid[fl]      = 1'b1;
                        n_dirty[fl]      = (r_item.cmd == CMD_WRITE);
                    end
                    if (found || fill) begin
                        for (int l = 0; l < LANES; l++) begin
                            we[l] = ins[l];
                            if (fill && LANE_W'(l) == tl) begin
                                wd[l][RAM_W-1:AGE_W] = r_item.tag;
                                // a line filled while invalid gets age zero, unless LRU mode sets it below
                                if (!vld[l]) wd[l][AGE_W-1:0] = '0;
                            end
                            if (!i_cfg.replace_policy) begin
                                if (LANE_W'(l) == tl) begin
                                    wd[l][AGE_W-1:0] = wm;
                                end else if (vld[l] && (found ? (rage[l] > ref_age)
                                                              : (rage[l] != '0))) begin
                                    wd[l][AGE_W-1:0] = rage[l] - 3'd1;
                                end
                            end
                        end
                    end
                end
            end
            B_FLUSH: begin
                for (int l = 0; l < LANES; l++) begin
                    fl = {r_row, LANE_W'(l)};
                    if ({1'b0, fl} < lim && r_valid[fl] && r_dirty[fl]) begin
                        pc         = pc + 9'd1;
                        n_dirty[fl] = 1'b0;
                    end
                end
                n_fcnt = r_fcnt + pc;
                n_row  = r_row + 1'b1;
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_ovalid         = 1'b1;
                    n_res            = '0;
                    n_res.mem_writes = n_fcnt;
                end
            end
            default: ;
        endcase
        if (i_seed.load) begin
            n_lfsr = (i_seed.seed == 16'h0000) ? 16'h0001 : i_seed.seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_item;
        end
        r_res  <= n_res;
        r_row  <= n_row;
        r_fcnt <= n_fcnt;
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_lfsr   <= 16'h0001;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_dirty  <= n_dirty;
            r_lfsr   <= n_lfsr;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_res;
endmodule

FILE: hdl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag, valid, dirty and age controller of a set-associative cache.
// ----------------------------------------------------------------------------
// A read or write access starts the per-way tag/age RAM read of the set's row
// in the idle state of the lookup unit; the lookup state then compares, picks a
// way and writes tags, ages and state back. A flush in write-back mode passes
// the same states, then walks the 256 lines eight per cycle in the flush state;
// in write-through mode it ends after the lookup state. A two-word queue after
// the address decoder accepts words while the lookup unit and output are busy.
module set_assoc_cache_tag_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // hit, allocated, line_index[7:0],
                                        // mem_reads, mem_writes[8:0], zero pad
    input  logic        i_cfg_we,
    input  logic [sactc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sactc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sactc_pkg::*;

    t_cfg    r_cfg;
    t_seed   seed;
    logic    qvalid, pop;
    t_item   item;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_policy    <= 1'b0;
            r_cfg.replace_policy  <= 1'b0;
            r_cfg.offset_bits     <= 4'd2;
            r_cfg.line_count_log2 <= 4'd8;
            r_cfg.ways_log2       <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WRITE_POLICY:   r_cfg.write_policy    <= i_cfg_data[0];
                CFG_REPLACE_POLICY: r_cfg.replace_policy  <= i_cfg_data[0];
                CFG_OFFSET_BITS:    r_cfg.offset_bits     <= i_cfg_data[3:0];
                CFG_LINES_LOG2:     r_cfg.line_count_log2 <= i_cfg_data[3:0];
                CFG_WAYS_LOG2:      r_cfg.ways_log2       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign seed.load = i_rst_n && i_cfg_we && (i_cfg_addr == CFG_RANDOM_SEED);
    assign seed.seed = i_cfg_data;

    sactc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_addr   (s_axis_tdata),
        .o_qvalid (qvalid),
        .o_item   (item),
        .i_pop    (pop)
    );

    sactc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_seed   (seed),
        .i_qvalid (qvalid),
        .i_item   (item),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tdata = {4'b0000, res.mem_writes, res.mem_reads, res.line_index,
                           res.allocated, res.hit};

    a_hit_xor_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(res.hit && res.allocated))
        else $error("hit and allocated both set");

    a_read_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.mem_reads == res.allocated))
        else $error("memory read without fill");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !res.hit && !res.allocated) |-> (res.line_index == '0))
        else $error("line index set without hit or fill");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qvalid)
        else $error("pop from empty queue");
endmodule

FILE: sim/cache_tag_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cache_tag_checker
// Watches the access and result streams, keeps its own model of the tag,
// valid, dirty and age arrays and compares every result word in order.
// ----------------------------------------------------------------------------
module cache_tag_checker
    import sactc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [23:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    logic        wpol, rpol;
    logic [3:0]  offs, lines_l2;
    logic [1:0]  ways_l2;
    logic [15:0] lfsr;
    logic        valid_q [LINES];
    logic        dirty_q [LINES];
    logic [31:0] tag_q   [LINES];
    int          age_q   [LINES];
    logic [23:0] expected_words [$];

    assign o_pending = expected_words.size();

    function automatic int eff_lines();
        return (lines_l2 > 8) ? 8 : lines_l2;
    endfunction

    function automatic int eff_ways();
        int w;
        w = ways_l2;
        if (w > eff_lines()) w = eff_lines();
        return w;
    endfunction

    function automatic void age_touch(int base, int nw, int tgt, bit was_hit);
        int r;
        r = age_q[tgt];
        for (int i = base; i < base + nw; i++) begin
            if (i != tgt && valid_q[i]) begin
                if (was_hit ? (age_q[i] > r) : (age_q[i] > 0)) age_q[i]--;
            end
        end
        age_q[tgt] = nw - 1;
    endfunction

    function automatic logic [23:0] predict_access(logic [1:0] cmd, logic [31:0] addr);
        logic hit, alloc, mrd, chosen, found;
        int   idx, mwr, wl, nw, sb, base;
        logic [31:0] blk, tag, set;
        hit = 0; alloc = 0; mrd = 0; idx = 0; mwr = 0;
        if (cmd == CMD_FLUSH) begin
            if (wpol) begin
                for (int i = 0; i < (1 << eff_lines()); i++) begin
                    if (valid_q[i] && dirty_q[i]) begin
                        if (mwr < 511) mwr++;
                        dirty_q[i] = 0;
                    end
                end
            end
        end else if (cmd != CMD_NONE) begin
            wl = eff_ways(); nw = 1 << wl; sb = eff_lines() - wl;
            blk = addr >> offs;
            set = blk & ((32'd1 << sb) - 1);
            tag = (sb >= 32) ? 0 : blk >> sb;
            base = set << wl;
            found = 0;
            for (int i = base; i < base + nw; i++) begin
                if (!found && valid_q[i] && tag_q[i] == tag) begin
                    found = 1; idx = i;
                end
            end
            if (found) begin
                hit = 1;
                if (cmd == CMD_WRITE) begin
                    if (!wpol) mwr = 1;
                    else dirty_q[idx] = 1;
                end
                if (!rpol) age_touch(base, nw, idx, 1);
            end else if (cmd == CMD_WRITE && !wpol) begin
                mwr = 1;
            end else begin
                chosen = 0;
                for (int i = base; i < base + nw; i++)
                    if (!chosen && !valid_q[i]) begin idx = i; chosen = 1; end
                if (!chosen && !rpol)
                    for (int i = base; i < base + nw; i++)
                        if (!chosen && age_q[i] == 0) begin idx = i; chosen = 1; end
                if (!chosen) begin
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
                    idx = base + (lfsr & (nw - 1));
                end
                if (wpol && valid_q[idx] && dirty_q[idx]) mwr = 1;
                mrd = 1; alloc = 1;
                valid_q[idx] = 1;
                tag_q[idx] = tag;
                dirty_q[idx] = (cmd == CMD_WRITE);
                if (!rpol) age_touch(base, nw, idx, 0);
            end
        end
        return {4'b0, mwr[8:0], mrd, idx[7:0], alloc, hit};
    endfunction

    logic [23:0] exp_w;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wpol <= 0; rpol <= 0; offs <= 2; lines_l2 <= 8; ways_l2 <= 1; lfsr <= 1;
            for (int i = 0; i < LINES; i++) begin
                valid_q[i] <= 0; dirty_q[i] <= 0; age_q[i] <= 0; tag_q[i] <= 0;
            end
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WRITE_POLICY:   wpol <= i_cfg_data[0];
                    CFG_REPLACE_POLICY: rpol <= i_cfg_data[0];
                    CFG_OFFSET_BITS:    offs <= i_cfg_data[3:0];
                    CFG_LINES_LOG2:     lines_l2 <= i_cfg_data[3:0];
                    CFG_WAYS_LOG2:      ways_l2 <= i_cfg_data[1:0];
                    CFG_RANDOM_SEED:    lfsr <= (i_cfg_data == 0) ? 16'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(predict_access(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w !== m_axis_tdata) begin
                        $display("%0t: mismatch hit/alloc/line/rd/wr expected %b/%b/%0d/%b/%0d actual %b/%b/%0d/%b/%0d",
                                 $time, exp_w[0], exp_w[1], exp_w[9:2], exp_w[10], exp_w[19:11],
                                 m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[9:2],
                                 m_axis_tdata[10], m_axis_tdata[19:11]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/tb_set_assoc_cache_tag_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_controller
// Drives directed and random reads, writes and flushes through several cache
// geometries and policies with random stalls; the checker compares results.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_controller;
    import sactc_pkg::*;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = 0;
    logic [1:0]            s_axis_tuser = 0;   // [1:0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [23:0]           m_axis_tdata;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;
    int                    errors, pending, cycles = 0;
    bit                    no_stall = 0;

    localparam int CYCLE_LIMIT = 400000;

    always #5 i_clk = ~i_clk;

    set_assoc_cache_tag_controller dut (.*);

    cache_tag_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_addr,
        .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= no_stall || ($urandom_range(99) >= 7);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, logic [31:0] addr);
        i_cfg_we <= 0;
        while (!no_stall && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int addr_span);
        t_cmd  c;
        logic [31:0] base;
        base = $urandom;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0:       c = CMD_FLUSH;
                1:       c = CMD_NONE;
                2,3,4,5,6,7,8: c = CMD_WRITE;
                default: c = CMD_READ;
            endcase
            if ($urandom_range(9) == 0) send_word(c, $urandom);
            else send_word(c, base + $urandom_range(addr_span));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: reset geometry, all commands and field extremes
        send_word(CMD_READ, 32'h0);
        send_word(CMD_READ, 32'h0);
        send_word(CMD_WRITE, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 32'hFFFF_FFFF);
        send_word(CMD_FLUSH, 32'h1234_5678);
        send_word(CMD_NONE, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) send_word(CMD_READ, k << 10);
        drain();
        cfg_write(CFG_WRITE_POLICY, 16'd1);
        for (int k = 0; k < 6; k++) send_word(CMD_WRITE, k << 10);
        send_word(CMD_READ, 32'h0);
        send_word(CMD_FLUSH, 0);
        send_word(CMD_FLUSH, 0);
        drain();
        // sweep of settings, extremes included
        for (int ph = 0; ph < 12; ph++) begin
            cfg_write(CFG_WRITE_POLICY, 16'(ph[0]));
            cfg_write(CFG_REPLACE_POLICY, 16'(ph[1]));
            cfg_write(CFG_OFFSET_BITS,
                      16'(ph == 0 ? 0 : ph == 1 ? 15 : $urandom_range(12)));
            cfg_write(CFG_LINES_LOG2,
                      16'(ph == 2 ? 0 : ph == 3 ? 15 : $urandom_range(8)));
            cfg_write(CFG_WAYS_LOG2,
                      16'(ph == 4 ? 0 : ph == 5 ? 3 : $urandom_range(3)));
            cfg_write(CFG_RANDOM_SEED,
                      ph == 6 ? 16'h0000 : ph == 7 ? 16'hFFFF : 16'($urandom));
            no_stall = (ph == 8);
            random_phase(100, ph[2] ? 32'h3_FFFF : 32'h3FFF);
            drain();
        end
        no_stall = 0;
        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
